>>> rtl/scedf_pkg.sv
// Shared types, widths, register indexes and helpers for the spin chain
// exchange/DMI effective field block. No dependencies.
`timescale 1ns / 1ps

package scedf_pkg;

   localparam int MAX_SITES = 4096;
   // sites_seen saturates at MAX_SITES+1
   localparam int SEEN_W    = $clog2(MAX_SITES + 2);

   localparam int IDX_W  = 13;
   localparam int MAG_W  = 18;
   localparam int CPL_W  = 32;
   localparam int SCL_W  = 20;
   localparam int FLD_W  = 40;
   localparam int DIF_W  = MAG_W + 1;
   localparam int OPA_W  = 36;
   localparam int OPB_W  = 20;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int Q_W    = ACC_W - 16;

   localparam int STEP_W = 5;
   localparam int PK_W   = 4;
   localparam logic [STEP_W-1:0] STEP_LAST_ISSUE = STEP_W'(14);
   localparam logic [STEP_W-1:0] STEP_COMBINE    = STEP_W'(16);

   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);
   localparam logic signed [OPB_W-1:0] ONE_Q16  = OPB_W'(65536);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_FERRO       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANISO       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DMI_EN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DMI_X       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DMI_Y       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DMI_Z       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_ONLY = 3'd6;

   typedef struct packed {
      logic                    ferro;
      logic signed [CPL_W-1:0] aniso;
      logic                    dmi_en;
      logic signed [CPL_W-1:0] dmi_x;
      logic signed [CPL_W-1:0] dmi_y;
      logic signed [CPL_W-1:0] dmi_z;
      logic                    region_only;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{ferro: 1'b1, default: '0};

   typedef struct packed {
      logic signed [MAG_W-1:0] mag_x;
      logic signed [MAG_W-1:0] mag_y;
      logic signed [MAG_W-1:0] mag_z;
      logic signed [CPL_W-1:0] coupling;
      logic                    in_gradient;
      logic signed [SCL_W-1:0] scale;
      logic                    chain_end;
   } site_type;

   // three-site window: left and middle site plus the two bonds around the middle
   typedef struct packed {
      logic signed [MAG_W-1:0] left_x;
      logic signed [MAG_W-1:0] left_y;
      logic signed [MAG_W-1:0] left_z;
      logic signed [MAG_W-1:0] mid_z;
      logic signed [CPL_W-1:0] left_j;
      logic signed [CPL_W-1:0] mid_j;
      logic                    mid_region;
      logic signed [SCL_W-1:0] mid_scale;
   } win_type;

   function automatic logic signed [FLD_W-1:0] sat_field(input logic signed [Q_W-1:0] v);
      logic signed [FLD_W-1:0] r;
      r = v[FLD_W-1:0];
      if (v[Q_W-1] && !(&v[Q_W-2:FLD_W-1]))
         r = {1'b1, {(FLD_W-1){1'b0}}};
      else if (!v[Q_W-1] && (|v[Q_W-2:FLD_W-1]))
         r = {1'b0, {(FLD_W-1){1'b1}}};
      return r;
   endfunction

endpackage

>>> rtl/scedf_mul.sv
// Shared signed multiplier, 36 x 20 bits, product registered.
// Depends on scedf_pkg for operand widths.
`timescale 1ns / 1ps

module scedf_mul import scedf_pkg::*; (
   input  logic                     clock,
   input  logic signed [OPA_W-1:0]  op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/scedf_core.sv
// Step sequencer around the shared multiplier: exchange sums, DMI cross
// products, gradient scaling and the final saturated combine.
// Depends on scedf_pkg and scedf_mul.
`timescale 1ns / 1ps

module scedf_core import scedf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    out_free,
   input  cfg_type                 cfg,
   input  win_type                 win,
   input  site_type                cur,
   output logic                    busy,
   output logic                    finish,
   output logic signed [FLD_W-1:0] field_x,
   output logic signed [FLD_W-1:0] field_y,
   output logic signed [FLD_W-1:0] field_z
);

   logic                     busy_ff, busy_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;
   logic                     pv_ff, pv_in;
   logic [PK_W-1:0]          pk_ff, pk_in;
   logic                     issue;
   logic [PK_W-1:0]          k;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [OPB_W-1:0]  scl_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  base, pext, sum;
   logic                     sub;
   logic signed [Q_W-1:0]    q;
   logic signed [Q_W-1:0]    aniso_q;

   logic signed [DIF_W-1:0]  d_ff [3];
   logic signed [DIF_W-1:0]  d_in [3];
   logic signed [OPA_W-1:0]  h_ff [3];
   logic signed [OPA_W-1:0]  h_in [3];
   logic signed [OPA_W-1:0]  c_ff [3];
   logic signed [OPA_W-1:0]  c_in [3];
   logic signed [Q_W-1:0]    e_ff [3];
   logic signed [Q_W-1:0]    e_in [3];
   logic signed [Q_W-1:0]    tot_x, tot_y, tot_z;

   // ---- sequencer
   assign issue  = busy_ff && (cnt_ff <= STEP_LAST_ISSUE);
   assign k      = cnt_ff[PK_W-1:0];
   assign finish = busy_ff && (cnt_ff == STEP_COMBINE) && out_free;
   assign busy   = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff != STEP_COMBINE)
            cnt_in = cnt_ff + 1'b1;
         else if (out_free)
            busy_in = 1'b0;
      end
   end

   assign pv_in = issue;
   assign pk_in = k;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         pv_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         pv_ff   <= pv_in;
      end
   end

   // ---- operand schedule, one product per step
   // gradient scale: 1.0 outside the region unless restricted, 0 when DMI is off
   always_comb begin
      scl_b = '0;
      if (cfg.dmi_en) begin
         if (win.mid_region)
            scl_b = win.mid_scale;
         else if (!cfg.region_only)
            scl_b = ONE_Q16;
      end
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (k)
         4'd0:  begin op_a = OPA_W'(win.left_j); op_b = OPB_W'(win.left_x); end
         4'd1:  begin op_a = OPA_W'(win.mid_j);  op_b = OPB_W'(cur.mag_x);  end
         4'd2:  begin op_a = OPA_W'(win.left_j); op_b = OPB_W'(win.left_y); end
         4'd3:  begin op_a = OPA_W'(win.mid_j);  op_b = OPB_W'(cur.mag_y);  end
         4'd4:  begin op_a = OPA_W'(win.left_j); op_b = OPB_W'(win.left_z); end
         4'd5:  begin op_a = OPA_W'(win.mid_j);  op_b = OPB_W'(cur.mag_z);  end
         // cross product D x d, first term added, second subtracted
         4'd6:  begin op_a = OPA_W'(cfg.dmi_y);  op_b = OPB_W'(d_ff[2]);    end
         4'd7:  begin op_a = OPA_W'(cfg.dmi_z);  op_b = OPB_W'(d_ff[1]);    end
         4'd8:  begin op_a = OPA_W'(cfg.dmi_z);  op_b = OPB_W'(d_ff[0]);    end
         4'd9:  begin op_a = OPA_W'(cfg.dmi_x);  op_b = OPB_W'(d_ff[2]);    end
         4'd10: begin op_a = OPA_W'(cfg.dmi_x);  op_b = OPB_W'(d_ff[1]);    end
         4'd11: begin op_a = OPA_W'(cfg.dmi_y);  op_b = OPB_W'(d_ff[0]);    end
         4'd12: begin op_a = c_ff[0];            op_b = scl_b;              end
         4'd13: begin op_a = c_ff[1];            op_b = scl_b;              end
         4'd14: begin op_a = c_ff[2];            op_b = scl_b;              end
         default: ;
      endcase
   end

   scedf_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // ---- accumulate and round (nearest, ties up: +half then floor)
   assign pext = ACC_W'(prod);
   assign sub  = (pk_ff == 4'd7) || (pk_ff == 4'd9) || (pk_ff == 4'd11);
   assign base = (pk_ff[0] && (pk_ff < 4'd12)) ? acc_ff : RND_HALF;
   assign sum  = sub ? (base - pext) : (base + pext);
   assign q    = sum[ACC_W-1:16];

   always_comb begin
      aniso_q = '0;
      if (!cfg.ferro)
         aniso_q = (win.mid_z > 18'sd0) ? Q_W'(cfg.aniso) : -Q_W'(cfg.aniso);
   end

   always_comb begin
      acc_in = acc_ff;
      h_in   = h_ff;
      c_in   = c_ff;
      e_in   = e_ff;
      d_in   = d_ff;
      // the new site sits in cur from the first step on
      if (busy_ff && (cnt_ff == '0)) begin
         d_in[0] = DIF_W'(cur.mag_x) - DIF_W'(win.left_x);
         d_in[1] = DIF_W'(cur.mag_y) - DIF_W'(win.left_y);
         d_in[2] = DIF_W'(cur.mag_z) - DIF_W'(win.left_z);
      end
      if (pv_ff) begin
         case (pk_ff)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10: acc_in = sum;
            4'd1:  h_in[0] = OPA_W'(q);
            4'd3:  h_in[1] = OPA_W'(q);
            4'd5:  h_in[2] = OPA_W'(q);
            4'd7:  c_in[0] = OPA_W'(q);
            4'd9:  c_in[1] = OPA_W'(q);
            4'd11: c_in[2] = OPA_W'(q);
            4'd12: e_in[0] = q;
            4'd13: e_in[1] = q;
            4'd14: e_in[2] = q + aniso_q;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pk_ff  <= pk_in;
      acc_ff <= acc_in;
      h_ff   <= h_in;
      c_ff   <= c_in;
      e_ff   <= e_in;
      d_ff   <= d_in;
   end

   // ---- combine: exchange negated when not ferromagnetic
   assign tot_x = cfg.ferro ? (e_ff[0] + Q_W'(h_ff[0])) : (e_ff[0] - Q_W'(h_ff[0]));
   assign tot_y = cfg.ferro ? (e_ff[1] + Q_W'(h_ff[1])) : (e_ff[1] - Q_W'(h_ff[1]));
   assign tot_z = cfg.ferro ? (e_ff[2] + Q_W'(h_ff[2])) : (e_ff[2] - Q_W'(h_ff[2]));

   assign field_x = sat_field(tot_x);
   assign field_y = sat_field(tot_y);
   assign field_z = sat_field(tot_z);

   // ---- checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("start while sequence running");

   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && (cnt_ff == '0))
      else $error("sequence did not begin at first step");

   a_tag: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> busy_ff && ((STEP_W'(pk_ff) + 1'b1) == cnt_ff))
      else $error("product tag out of step with sequencer");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (cnt_ff == STEP_COMBINE) && !out_free |=>
         busy_ff && (cnt_ff == STEP_COMBINE))
      else $error("combine step left while output blocked");

   a_done: assert property (@(posedge clock) disable iff (reset)
      finish |=> !busy_ff && !pv_ff)
      else $error("sequencer still active after finish");

endmodule

>>> rtl/spin_chain_exchange_dmi_field.sv
// A middle site's field word is computed after the next site is taken and reaches rsp
//   through the output register. Each started sequence runs fifteen products through the
//   one shared 36x20 multiplier, then a combine step; sites 0 and 1 of a chain and a short
//   chain end are taken without one. A finished word waits in the output register, a new
//   site is taken meanwhile; the sequencer holds only if that register is still full.
// Reset (synchronous): registers to defaults (ferromagnetic set, rest zero), window empty.
`timescale 1ns / 1ps

module spin_chain_exchange_dmi_field import scedf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // site word in
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [111:0]         req_tdata,  // mag_x, mag_y, mag_z, right_coupling, gradient_scale
   input  logic                 req_tuser,  // in_gradient
   input  logic                 req_tlast,  // chain_end
   // field word out
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [135:0]         rsp_tdata,  // site_index, field_x, field_y, field_z
   output logic                 rsp_tlast,  // last_site
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CPL_W-1:0]     csr_data
);

   cfg_type             cfg_ff, cfg_in;
   win_type             win_ff, win_in;
   site_type            cur_ff, cur_in;
   site_type            req_site, src;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [135:0]        rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept, start, upd, out_free;
   logic                busy, finish;
   logic signed [FLD_W-1:0] field_x, field_y, field_z;
   logic [IDX_W-1:0]    site_index;

   // the middle magnetization x/y is only needed as the next left site
   logic signed [MAG_W-1:0] mid_x_ff, mid_y_ff, mid_x_in, mid_y_in;

   // ---- register port
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FERRO:       cfg_in.ferro       = csr_data[0];
            REG_ANISO:       cfg_in.aniso       = csr_data;
            REG_DMI_EN:      cfg_in.dmi_en      = csr_data[0];
            REG_DMI_X:       cfg_in.dmi_x       = csr_data;
            REG_DMI_Y:       cfg_in.dmi_y       = csr_data;
            REG_DMI_Z:       cfg_in.dmi_z       = csr_data;
            REG_REGION_ONLY: cfg_in.region_only = csr_data[0];
            default: ;
         endcase
      end
   end

   // ---- input unpack
   assign req_site.mag_x       = req_tdata[17:0];
   assign req_site.mag_y       = req_tdata[35:18];
   assign req_site.mag_z       = req_tdata[53:36];
   assign req_site.coupling    = req_tdata[85:54];
   assign req_site.scale       = req_tdata[105:86];
   assign req_site.in_gradient = req_tuser;
   assign req_site.chain_end   = req_tlast;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (seen_ff >= SEEN_W'(2));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign cur_in = accept ? req_site : cur_ff;

   // ---- window slide; a site that starts a sequence slides in once the field it completes is out
   assign upd = (accept && !start) || finish;
   assign src = finish ? cur_ff : req_site;

   always_comb begin
      win_in  = win_ff;
      seen_in = seen_ff;
      if (upd) begin
         if (src.chain_end) begin
            seen_in = '0;
         end else begin
            win_in.left_x     = mid_x_ff;
            win_in.left_y     = mid_y_ff;
            win_in.left_z     = win_ff.mid_z;
            win_in.left_j     = win_ff.mid_j;
            win_in.mid_j      = src.coupling;
            win_in.mid_region = src.in_gradient;
            win_in.mid_scale  = src.scale;
            win_in.mid_z      = src.mag_z;
            if (seen_ff < SEEN_W'(MAX_SITES + 1))
               seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_comb begin
      mid_x_in = mid_x_ff;
      mid_y_in = mid_y_ff;
      if (upd && !src.chain_end) begin
         mid_x_in = src.mag_x;
         mid_y_in = src.mag_y;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      mid_x_ff <= mid_x_in;
      mid_y_ff <= mid_y_in;
      win_ff   <= win_in;
   end

   // ---- field sequencer
   scedf_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .cfg      (cfg_ff),
      .win      (win_ff),
      .cur      (cur_ff),
      .busy     (busy),
      .finish   (finish),
      .field_x  (field_x),
      .field_y  (field_y),
      .field_z  (field_z)
   );

   // ---- output register
   assign site_index = IDX_W'(seen_ff - 1'b1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, field_z, field_y, field_x, site_index};
         rsp_last_in  = cur_ff.chain_end;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
